/* rtl/i2crm_pkg.sv */
// Shared types and codes for the I2C register master.
// No dependencies; used by the front, back and top-level files.
package i2crm_pkg;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] REG_DEVICE_ADDR = 2'd2;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd200;
    localparam logic [3:0]  RETRY_LIMIT_RESET = 4'd5;
    localparam logic [7:0]  DEVICE_ADDR_RESET = 8'hD0;

    // classified input item as it sits in the queue
    typedef struct packed {
        logic       is_cmd;
        logic       is_read;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_item;

    // queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       finished;
        logic       success;
        logic [7:0] read_data;
        logic       rejected;
    } t_result;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [3:0]  retry_limit;
        logic [7:0]  device_address;
    } t_cfg;

endpackage

/* rtl/i2c_register_master_with_retry_top.sv */
// I2C register master with retry: top level with APB register bank.
// Instantiates i2crm_front and i2crm_back; uses i2crm_pkg.
//
// Each item is one tick or a command and gives one result item. Throughput
// is one item per clock while neither queue nor output stalls: the front
// queue (two entries) takes a new item each cycle; the back-end sequencer
// advances one tick per item; an item passes a queue entry, then the output
// register. The line waveform is counted in items, half_period_ticks items
// per segment; bus speed is set by the caller's tick rate. The user must
// write configuration via APB only while the block idles; it is unchecked.
module i2c_register_master_with_retry_top #(
    parameter int TICK_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_register_address,
    input  logic [7:0]  i_write_data,
    input  logic        i_sda_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_sda_drive,
    output logic        o_busy_res,
    output logic        o_finished,
    output logic        o_success,
    output logic [7:0]  o_read_data,
    output logic        o_rejected,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    i2crm_pkg::t_cfg    r_cfg;
    i2crm_pkg::t_head   w_head;
    i2crm_pkg::t_result w_result;
    logic               w_pop;
    logic [1:0]         w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= i2crm_pkg::HALF_PERIOD_RESET;
            r_cfg.retry_limit       <= i2crm_pkg::RETRY_LIMIT_RESET;
            r_cfg.device_address    <= i2crm_pkg::DEVICE_ADDR_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                i2crm_pkg::REG_HALF_PERIOD: r_cfg.half_period_ticks <= pwdata[15:0];
                i2crm_pkg::REG_RETRY_LIMIT: r_cfg.retry_limit       <= pwdata[3:0];
                i2crm_pkg::REG_DEVICE_ADDR: r_cfg.device_address    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            i2crm_pkg::REG_HALF_PERIOD: prdata = {16'd0, r_cfg.half_period_ticks};
            i2crm_pkg::REG_RETRY_LIMIT: prdata = {28'd0, r_cfg.retry_limit};
            i2crm_pkg::REG_DEVICE_ADDR: prdata = {24'd0, r_cfg.device_address};
            default:                    prdata = 32'd0;
        endcase
    end

    i2crm_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_register_address (i_register_address),
        .i_write_data       (i_write_data),
        .i_sda_in           (i_sda_in),
        .i_pop              (w_pop),
        .o_head             (w_head)
    );

    i2crm_back #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_result)
    );

    assign o_scl_level = w_result.scl_level;
    assign o_sda_level = w_result.sda_level;
    assign o_sda_drive = w_result.sda_drive;
    assign o_busy_res  = w_result.busy_res;
    assign o_finished  = w_result.finished;
    assign o_success   = w_result.success;
    assign o_read_data = w_result.read_data;
    assign o_rejected  = w_result.rejected;

endmodule

/* rtl/i2crm_front.sv */
// Front end: accepts input items, decodes the kind and holds them in a
// two-entry queue for the sequencer. Depends on i2crm_pkg.
module i2crm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_register_address,
    input  logic [7:0]          i_write_data,
    input  logic                i_sda_in,
    input  logic                i_pop,
    output i2crm_pkg::t_head    o_head
);

    i2crm_pkg::t_item r_mem [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_count;
    i2crm_pkg::t_item w_item;
    logic             w_push, w_pop;

    always_comb begin
        w_item.is_cmd  = (i_kind == i2crm_pkg::KIND_WRITE) || (i_kind == i2crm_pkg::KIND_READ);
        w_item.is_read = (i_kind == i2crm_pkg::KIND_READ);
        w_item.register_address = i_register_address;
        w_item.write_data       = i_write_data;
        w_item.sda_in           = i_sda_in;
    end

    assign o_in_stall   = (r_count == 2'd2);
    assign w_push       = i_in_valid && !o_in_stall;
    assign w_pop        = i_pop && (r_count != 2'd0);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= !r_wr_ptr;
            if (w_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

/* rtl/i2crm_back.sv */
// Back end: tick-driven I2C bit sequencer with retry, one queued item per
// step, result held in an output register. Depends on i2crm_pkg.
module i2crm_back #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2crm_pkg::t_head    i_head,
    output logic                o_pop,
    input  i2crm_pkg::t_cfg     i_cfg,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output i2crm_pkg::t_result  o_result
);

    localparam int LW = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ISTOP_A, PH_ISTOP_B, PH_START_A, PH_START_B, PH_START_C,
        PH_WLOW, PH_WHIGH, PH_WTAIL, PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_TAIL,
        PH_GAP, PH_RLOW, PH_RHIGH, PH_RTAIL, PH_NLOW, PH_NHIGH, PH_NTAIL,
        PH_ESTOP_A, PH_ESTOP_B
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [3:0]              r_bit, n_bit;
    logic [TICK_WIDTH-1:0]   r_tick, n_tick;
    logic [7:0]              r_shift, n_shift;
    logic [3:0]              r_attempt, n_attempt;
    logic                    r_all_acked, n_all_acked;
    logic [7:0]              r_captured, n_captured;
    logic                    r_is_read, n_is_read;
    logic [7:0]              r_held_reg, n_held_reg;
    logic [7:0]              r_held_data, n_held_data;
    logic [1:0]              r_byte_step, n_byte_step;
    logic                    r_out_valid;
    i2crm_pkg::t_result      r_out, n_out;

    logic [TICK_WIDTH-1:0]   w_tick_inc;
    logic [LW-1:0]           w_limit, w_hp, w_tmax;
    logic                    w_bb_en;
    logic [1:0]              w_bb_step;
    logic [3:0]              w_att_inc, w_retry;
    logic                    w_sda;
    logic                    w_finished;

    assign o_pop       = i_head.valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    assign w_hp       = LW'(i_cfg.half_period_ticks);
    assign w_tmax     = LW'({TICK_WIDTH{1'b1}});
    assign w_limit    = (w_hp > w_tmax) ? w_tmax : w_hp;
    assign w_tick_inc = r_tick + TICK_WIDTH'(1);
    assign w_att_inc  = r_attempt + 4'd1;
    assign w_retry    = (i_cfg.retry_limit == 4'd0) ? 4'd1 : i_cfg.retry_limit;
    assign w_sda      = i_head.item.sda_in;

    always_comb begin
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_tick      = r_tick;
        n_shift     = r_shift;
        n_attempt   = r_attempt;
        n_all_acked = r_all_acked;
        n_captured  = r_captured;
        n_is_read   = r_is_read;
        n_held_reg  = r_held_reg;
        n_held_data = r_held_data;
        n_byte_step = r_byte_step;
        w_bb_en     = 1'b0;
        w_bb_step   = r_byte_step;
        w_finished  = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_head.item.is_cmd) begin
                n_is_read   = i_head.item.is_read;
                n_held_reg  = i_head.item.register_address;
                n_held_data = i_head.item.write_data;
                n_attempt   = 4'd0;
                n_tick      = '0;
                n_byte_step = 2'd0;
                n_phase     = PH_ISTOP_A;
            end
        end else if ((LW'(w_tick_inc) >= w_limit) || (w_tick_inc == '0)) begin
            n_tick = '0;
            unique case (r_phase)
                PH_ISTOP_A: n_phase = PH_ISTOP_B;
                PH_ISTOP_B, PH_START_A: begin
                    if (r_phase == PH_ISTOP_B) begin
                        n_byte_step = 2'd0;
                        n_all_acked = 1'b1;
                        n_phase     = PH_START_A;
                    end else begin
                        n_phase = PH_START_B;
                    end
                end
                PH_START_B: n_phase = PH_START_C;
                PH_START_C: w_bb_en = 1'b1;
                PH_WLOW:    n_phase = PH_WHIGH;
                PH_WHIGH:   n_phase = (r_bit >= 4'd7) ? PH_ACK_LOW : PH_WTAIL;
                PH_WTAIL: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = r_bit + 4'd1;
                    n_phase = PH_WLOW;
                end
                PH_ACK_LOW: n_phase = PH_ACK_HIGH;
                PH_ACK_HIGH: begin
                    if (w_sda) n_all_acked = 1'b0;
                    n_phase = PH_ACK_TAIL;
                end
                PH_ACK_TAIL: begin
                    case (r_byte_step)
                        2'd0: begin
                            w_bb_en   = 1'b1;
                            w_bb_step = 2'd1;
                        end
                        2'd1: begin
                            if (r_is_read) begin
                                n_phase = PH_GAP;
                            end else begin
                                w_bb_en   = 1'b1;
                                w_bb_step = 2'd2;
                            end
                        end
                        2'd2: n_phase = PH_ESTOP_A;
                        default: begin
                            n_bit   = 4'd0;
                            n_shift = 8'd0;
                            n_phase = PH_RLOW;
                        end
                    endcase
                end
                PH_GAP: begin
                    n_byte_step = 2'd3;
                    n_phase     = PH_START_A;
                end
                PH_RLOW: n_phase = PH_RHIGH;
                PH_RHIGH: begin
                    n_shift = {r_shift[6:0], w_sda};
                    n_phase = PH_RTAIL;
                end
                PH_RTAIL: begin
                    if (r_bit >= 4'd7) begin
                        n_captured = r_shift;
                        n_phase    = PH_NLOW;
                    end else begin
                        n_bit   = r_bit + 4'd1;
                        n_phase = PH_RLOW;
                    end
                end
                PH_NLOW:    n_phase = PH_NHIGH;
                PH_NHIGH:   n_phase = PH_NTAIL;
                PH_NTAIL:   n_phase = PH_ESTOP_A;
                PH_ESTOP_A: n_phase = PH_ESTOP_B;
                PH_ESTOP_B: begin
                    if (r_all_acked) begin
                        n_phase    = PH_IDLE;
                        w_finished = 1'b1;
                    end else begin
                        n_attempt = w_att_inc;
                        if (w_att_inc >= w_retry) begin
                            n_phase    = PH_IDLE;
                            w_finished = 1'b1;
                        end else begin
                            n_byte_step = 2'd0;
                            n_all_acked = 1'b1;
                            n_phase     = PH_START_A;
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end else begin
            n_tick = w_tick_inc;
        end

        // load the next byte onto the shifter
        if (w_bb_en) begin
            n_byte_step = w_bb_step;
            case (w_bb_step)
                2'd0:    n_shift = i_cfg.device_address;
                2'd1:    n_shift = r_held_reg;
                2'd2:    n_shift = r_held_data;
                default: n_shift = i_cfg.device_address + 8'd1;
            endcase
            n_bit   = 4'd0;
            n_phase = PH_WLOW;
        end

        // line levels after this item
        case (n_phase)
            PH_IDLE:    {n_out.scl_level, n_out.sda_level, n_out.sda_drive} = 3'b001;
            PH_ISTOP_A: {n_out.scl_level, n_out.sda_level, n_out.sda_drive} = 3'b101;
            PH_ISTOP_B, PH_START_A, PH_ESTOP_B:
                        {n_out.scl_level, n_out.sda_level, n_out.sda_drive} = 3'b111;
            PH_START_B, PH_ESTOP_A:
                        {n_out.scl_level, n_out.sda_level, n_out.sda_drive} = 3'b101;
            PH_START_C: {n_out.scl_level, n_out.sda_level, n_out.sda_drive} = 3'b001;
            PH_WLOW, PH_WTAIL:
                        {n_out.scl_level, n_out.sda_level, n_out.sda_drive} =
                            {1'b0, n_shift[7], 1'b1};
            PH_WHIGH:   {n_out.scl_level, n_out.sda_level, n_out.sda_drive} =
                            {1'b1, n_shift[7], 1'b1};
            PH_ACK_HIGH, PH_RHIGH, PH_NHIGH:
                        {n_out.scl_level, n_out.sda_level, n_out.sda_drive} = 3'b110;
            default:    {n_out.scl_level, n_out.sda_level, n_out.sda_drive} = 3'b010;
        endcase
        n_out.busy_res  = (n_phase != PH_IDLE);
        n_out.finished  = w_finished;
        n_out.success   = n_all_acked;
        n_out.read_data = n_captured;
        n_out.rejected  = (r_phase != PH_IDLE) && i_head.item.is_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit       <= 4'd0;
            r_tick      <= '0;
            r_shift     <= 8'd0;
            r_attempt   <= 4'd0;
            r_all_acked <= 1'b1;
            r_captured  <= 8'd0;
            r_is_read   <= 1'b0;
            r_held_reg  <= 8'd0;
            r_held_data <= 8'd0;
            r_byte_step <= 2'd0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_bit       <= n_bit;
                r_tick      <= n_tick;
                r_shift     <= n_shift;
                r_attempt   <= n_attempt;
                r_all_acked <= n_all_acked;
                r_captured  <= n_captured;
                r_is_read   <= n_is_read;
                r_held_reg  <= n_held_reg;
                r_held_data <= n_held_data;
                r_byte_step <= n_byte_step;
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* tb/i2c_register_master_with_retry_top_test.sv */
// Self-checking test of the I2C register master with retry: a directed table,
// then random command/tick traffic, checked against a bit-level line predictor.
// Depends on rtl/i2crm_pkg.sv and the i2c_register_master_with_retry_top RTL.
module i2c_register_master_with_retry_top_test;

    localparam logic [1:0] KIND_SPARE = 2'd3;   // unused kind, acts as a tick
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int DIR_ROWS = 19;

    // line segments of one transaction
    typedef enum logic [4:0] {
        S_IDLE, S_PSTOP_A, S_PSTOP_B, S_START_A, S_START_B, S_START_C,
        S_BIT_LO, S_BIT_HI, S_BIT_END, S_ACK_LO, S_ACK_HI, S_ACK_END,
        S_GAP, S_RD_LO, S_RD_HI, S_RD_END, S_NAK_LO, S_NAK_HI, S_NAK_END,
        S_STOP_A, S_STOP_B
    } t_seg;

    typedef enum logic [1:0] {ACKS_CLEAN, ACKS_FLAKY, ACKS_DEAD} t_ack_mode;

    typedef struct packed {
        bit                 is_cfg;
        logic [1:0]         reg_idx;
        logic [15:0]        reg_val;
        logic [1:0]         kind;
        logic [7:0]         reg_addr;
        logic [7:0]         wdata;
        logic               sda;
        logic [11:0]        reps;      // 0: ticks until the transaction ends
        bit                 known;
        i2crm_pkg::t_result want;
    } t_row;

    localparam i2crm_pkg::t_result LINES_IDLE = '{scl_level: 1'b0, sda_level: 1'b0,
        sda_drive: 1'b1, busy_res: 1'b0, finished: 1'b0, success: 1'b1, read_data: 8'h00,
        rejected: 1'b0};
    localparam i2crm_pkg::t_result LINES_PRESTOP = '{scl_level: 1'b1, sda_level: 1'b0,
        sda_drive: 1'b1, busy_res: 1'b1, finished: 1'b0, success: 1'b1, read_data: 8'h00,
        rejected: 1'b0};
    localparam i2crm_pkg::t_result IDLE_NACK_FF = '{scl_level: 1'b0, sda_level: 1'b0,
        sda_drive: 1'b1, busy_res: 1'b0, finished: 1'b0, success: 1'b0, read_data: 8'hFF,
        rejected: 1'b0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind = i2crm_pkg::KIND_TICK;
    logic [7:0]  i_register_address = 8'h00;
    logic [7:0]  i_write_data = 8'h00;
    logic        i_sda_in = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_scl_level;
    logic        o_sda_level;
    logic        o_sda_drive;
    logic        o_busy_res;
    logic        o_finished;
    logic        o_success;
    logic [7:0]  o_read_data;
    logic        o_rejected;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    i2c_register_master_with_retry_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_kind(i_kind), .i_register_address(i_register_address),
        .i_write_data(i_write_data), .i_sda_in(i_sda_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_scl_level(o_scl_level), .o_sda_level(o_sda_level), .o_sda_drive(o_sda_drive),
        .o_busy_res(o_busy_res), .o_finished(o_finished), .o_success(o_success),
        .o_read_data(o_read_data), .o_rejected(o_rejected),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state and its copy of the register bank
    t_seg        m_seg;
    logic [3:0]  m_bit;
    logic [15:0] m_ticks;
    logic [7:0]  m_shift;
    logic [3:0]  m_attempt;
    logic        m_acked;
    logic [7:0]  m_rdbyte;
    logic        m_is_read;
    logic [7:0]  m_reg;
    logic [7:0]  m_data;
    logic [1:0]  m_step;    // byte on the line: address, register, data, address + 1
    logic [15:0] c_half;
    logic [3:0]  c_retry;
    logic [7:0]  c_dev;

    i2crm_pkg::t_result line_q [$];
    i2crm_pkg::t_result head_res;
    t_row        dir_plan [DIR_ROWS];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned calm = 0;
    int unsigned total_items = 0;
    int unsigned work_items = 0;
    int unsigned dir_items = 0;
    int unsigned n_writes = 0;
    int unsigned n_reads = 0;
    int unsigned n_ok = 0;
    int unsigned n_gave_up = 0;
    int unsigned n_rejected = 0;
    int unsigned n_cfg = 0;

    function automatic void load_byte(input logic [1:0] which);
        m_step = which;
        case (which)
            2'd0: m_shift = c_dev;
            2'd1: m_shift = m_reg;
            2'd2: m_shift = m_data;
            default: m_shift = c_dev + 8'd1;
        endcase
        m_bit = 4'd0;
        m_seg = S_BIT_LO;
    endfunction

    function automatic void new_attempt();
        m_step = 2'd0;
        m_acked = 1'b1;
        m_seg = S_START_A;
    endfunction

    // closes the current segment; 1 when the transaction is over
    function automatic bit close_segment(input logic sda);
        logic [3:0] lim;
        case (m_seg)
            S_PSTOP_A: m_seg = S_PSTOP_B;
            S_PSTOP_B: new_attempt();
            S_START_A: m_seg = S_START_B;
            S_START_B: m_seg = S_START_C;
            S_START_C: load_byte(m_step);
            S_BIT_LO:  m_seg = S_BIT_HI;
            S_BIT_HI:  m_seg = (m_bit >= 4'd7) ? S_ACK_LO : S_BIT_END;
            S_BIT_END: begin
                m_shift = {m_shift[6:0], 1'b0};
                m_bit = m_bit + 4'd1;
                m_seg = S_BIT_LO;
            end
            S_ACK_LO:  m_seg = S_ACK_HI;
            S_ACK_HI: begin
                if (sda) m_acked = 1'b0;
                m_seg = S_ACK_END;
            end
            S_ACK_END: begin
                case (m_step)
                    2'd0: load_byte(2'd1);
                    2'd1: begin
                        if (m_is_read) m_seg = S_GAP;
                        else load_byte(2'd2);
                    end
                    2'd2: m_seg = S_STOP_A;
                    default: begin
                        m_bit = 4'd0;
                        m_shift = 8'h00;
                        m_seg = S_RD_LO;
                    end
                endcase
            end
            S_GAP: begin
                m_step = 2'd3;
                m_seg = S_START_A;
            end
            S_RD_LO: m_seg = S_RD_HI;
            S_RD_HI: begin
                m_shift = {m_shift[6:0], sda};
                m_seg = S_RD_END;
            end
            S_RD_END: begin
                if (m_bit >= 4'd7) begin
                    m_rdbyte = m_shift;
                    m_seg = S_NAK_LO;
                end else begin
                    m_bit = m_bit + 4'd1;
                    m_seg = S_RD_LO;
                end
            end
            S_NAK_LO:  m_seg = S_NAK_HI;
            S_NAK_HI:  m_seg = S_NAK_END;
            S_NAK_END: m_seg = S_STOP_A;
            S_STOP_A:  m_seg = S_STOP_B;
            S_STOP_B: begin
                if (m_acked) begin
                    m_seg = S_IDLE;
                    return 1'b1;
                end
                m_attempt = m_attempt + 4'd1;
                lim = (c_retry == 4'd0) ? 4'd1 : c_retry;
                if (m_attempt >= lim) begin
                    m_seg = S_IDLE;
                    return 1'b1;
                end
                new_attempt();
            end
            default: m_seg = S_IDLE;
        endcase
        return 1'b0;
    endfunction

    function automatic i2crm_pkg::t_result predict_lines(input logic [1:0] k,
                                                         input logic [7:0] ra,
                                                         input logic [7:0] wd,
                                                         input logic sda);
        i2crm_pkg::t_result r;
        logic               is_cmd;
        is_cmd = (k == i2crm_pkg::KIND_WRITE) || (k == i2crm_pkg::KIND_READ);
        r.finished = 1'b0;
        r.rejected = 1'b0;
        if (m_seg == S_IDLE) begin
            if (is_cmd) begin
                m_is_read = (k == i2crm_pkg::KIND_READ);
                m_reg = ra;
                m_data = wd;
                m_attempt = 4'd0;
                m_ticks = 16'd0;
                m_step = 2'd0;
                m_seg = S_PSTOP_A;
            end
        end else begin
            r.rejected = is_cmd;
            m_ticks = m_ticks + 16'd1;
            if (m_ticks >= c_half || m_ticks == 16'd0) begin
                m_ticks = 16'd0;
                r.finished = close_segment(sda);
            end
        end
        case (m_seg)
            S_PSTOP_A, S_PSTOP_B, S_START_A, S_START_B, S_BIT_HI, S_ACK_HI, S_RD_HI,
            S_NAK_HI, S_STOP_A, S_STOP_B: r.scl_level = 1'b1;
            default: r.scl_level = 1'b0;
        endcase
        case (m_seg)
            S_IDLE, S_PSTOP_A, S_START_B, S_START_C, S_STOP_A: r.sda_level = 1'b0;
            S_BIT_LO, S_BIT_HI, S_BIT_END: r.sda_level = m_shift[7];
            default: r.sda_level = 1'b1;
        endcase
        case (m_seg)
            S_ACK_LO, S_ACK_HI, S_ACK_END, S_GAP, S_RD_LO, S_RD_HI, S_RD_END,
            S_NAK_LO, S_NAK_HI, S_NAK_END: r.sda_drive = 1'b0;
            default: r.sda_drive = 1'b1;
        endcase
        r.busy_res = (m_seg != S_IDLE);
        r.success = m_acked;
        r.read_data = m_rdbyte;
        return r;
    endfunction

    // line level offered by the target; only the acknowledge sample is steered
    function automatic logic pick_sda(input t_ack_mode mode);
        if (m_seg != S_ACK_HI) return 1'($urandom_range(0, 1));
        case (mode)
            ACKS_CLEAN: return 1'b0;
            ACKS_FLAKY: return ($urandom_range(0, 99) < 30);
            default:    return 1'b1;
        endcase
    endfunction

    function automatic t_row row_cfg(input logic [1:0] idx, input logic [15:0] val);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row row_item(input logic [1:0] k, input logic [7:0] ra,
                                      input logic [7:0] wd, input logic sda,
                                      input logic [11:0] reps);
        t_row r;
        r = '0;
        r.kind = k;
        r.reg_addr = ra;
        r.wdata = wd;
        r.sda = sda;
        r.reps = reps;
        return r;
    endfunction

    function automatic t_row row_check(input logic [1:0] k, input logic [7:0] ra,
                                       input logic [7:0] wd, input logic sda,
                                       input i2crm_pkg::t_result want);
        t_row r;
        r = row_item(k, ra, wd, sda, 12'd1);
        r.known = 1'b1;
        r.want = want;
        return r;
    endfunction

    task automatic send_item(input logic [1:0] k, input logic [7:0] ra, input logic [7:0] wd,
                             input logic sda, input bit known,
                             input i2crm_pkg::t_result want);
        i2crm_pkg::t_result pred;
        while (calm == 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= k;
        i_register_address <= ra;
        i_write_data <= wd;
        i_sda_in <= sda;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        total_items++;
        if (m_seg != S_IDLE || k == i2crm_pkg::KIND_WRITE || k == i2crm_pkg::KIND_READ)
            work_items++;
        if (m_seg == S_IDLE && k == i2crm_pkg::KIND_WRITE) n_writes++;
        if (m_seg == S_IDLE && k == i2crm_pkg::KIND_READ) n_reads++;
        pred = predict_lines(k, ra, wd, sda);
        if (pred.finished && pred.success) n_ok++;
        if (pred.finished && !pred.success) n_gave_up++;
        if (pred.rejected) n_rejected++;
        line_q.push_back(known ? want : pred);
        if (calm > 0) calm--;
        else if ($urandom_range(0, 99) < 2) calm = $urandom_range(10, 40);
    endtask

    // holds the sender until every expected result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (line_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        drain();
        repeat (3) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'h0000, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            i2crm_pkg::REG_HALF_PERIOD: c_half = val;
            i2crm_pkg::REG_RETRY_LIMIT: c_retry = val[3:0];
            i2crm_pkg::REG_DEVICE_ADDR: c_dev = val[7:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    // one command run to its end, with rejected commands and spare kinds mixed in
    task automatic run_txn(input bit hold_once);
        logic [1:0]  op;
        logic [1:0]  k;
        t_ack_mode   mode;
        int unsigned r;
        int unsigned n;
        repeat ($urandom_range(0, 2))
            send_item(i2crm_pkg::KIND_TICK, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0,
                      LINES_IDLE);
        op = $urandom_range(0, 1) ? i2crm_pkg::KIND_WRITE : i2crm_pkg::KIND_READ;
        r = $urandom_range(0, 9);
        mode = (r < 6) ? ACKS_CLEAN : (r < 9) ? ACKS_FLAKY : ACKS_DEAD;
        send_item(op, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, LINES_IDLE);
        n = 0;
        while (m_seg != S_IDLE) begin
            if (hold_once && n == 20) drain();
            r = $urandom_range(0, 99);
            if (r < 4) k = $urandom_range(0, 1) ? i2crm_pkg::KIND_WRITE : i2crm_pkg::KIND_READ;
            else if (r < 7) k = KIND_SPARE;
            else k = i2crm_pkg::KIND_TICK;
            send_item(k, 8'($urandom), 8'($urandom), pick_sda(mode), 1'b0, LINES_IDLE);
            n++;
        end
    endtask

    task automatic cmp_field(input string fld, input logic [7:0] want_v,
                             input logic [7:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want_v,
                         got_v);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= (calm == 0) && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (line_q.size() == 0) begin
                errors++;
                if (errors <= 40) $display("%0t: result item with none expected", $time);
            end else begin
                head_res = line_q.pop_front();
                cmp_field("scl_level", 8'(head_res.scl_level), 8'(o_scl_level));
                cmp_field("sda_level", 8'(head_res.sda_level), 8'(o_sda_level));
                cmp_field("sda_drive", 8'(head_res.sda_drive), 8'(o_sda_drive));
                cmp_field("busy_res", 8'(head_res.busy_res), 8'(o_busy_res));
                cmp_field("finished", 8'(head_res.finished), 8'(o_finished));
                cmp_field("success", 8'(head_res.success), 8'(o_success));
                cmp_field("read_data", head_res.read_data, o_read_data);
                cmp_field("rejected", 8'(head_res.rejected), 8'(o_rejected));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, line_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_row        row;
        int unsigned goal;
        dir_plan = '{
            row_check(i2crm_pkg::KIND_TICK,  8'h00, 8'h00, 1'b1, LINES_IDLE),
            row_check(KIND_SPARE,            8'hFF, 8'hFF, 1'b0, LINES_IDLE),
            row_cfg(i2crm_pkg::REG_HALF_PERIOD, 16'd0),
            row_cfg(i2crm_pkg::REG_RETRY_LIMIT, 16'd0),
            row_cfg(i2crm_pkg::REG_DEVICE_ADDR, 16'd255),
            row_check(i2crm_pkg::KIND_READ,  8'hFF, 8'hFF, 1'b1, LINES_PRESTOP),
            row_item(i2crm_pkg::KIND_WRITE,  8'h12, 8'h34, 1'b0, 12'd1),
            row_item(KIND_SPARE,             8'h00, 8'h00, 1'b1, 12'd1),
            row_item(i2crm_pkg::KIND_TICK,   8'h00, 8'h00, 1'b1, 12'd0),
            row_check(i2crm_pkg::KIND_TICK,  8'h00, 8'h00, 1'b0, IDLE_NACK_FF),
            row_cfg(i2crm_pkg::REG_HALF_PERIOD, 16'd1),
            row_cfg(i2crm_pkg::REG_RETRY_LIMIT, 16'd2),
            row_cfg(i2crm_pkg::REG_DEVICE_ADDR, 16'd0),
            row_item(i2crm_pkg::KIND_WRITE,  8'h00, 8'hFF, 1'b0, 12'd1),
            row_item(i2crm_pkg::KIND_TICK,   8'h00, 8'h00, 1'b1, 12'd0),
            row_check(i2crm_pkg::KIND_TICK,  8'h00, 8'h00, 1'b0, IDLE_NACK_FF),
            row_item(i2crm_pkg::KIND_READ,   8'h80, 8'h5A, 1'b0, 12'd1),
            row_item(i2crm_pkg::KIND_TICK,   8'h00, 8'h00, 1'b0, 12'd0),
            row_check(i2crm_pkg::KIND_TICK,  8'h00, 8'h00, 1'b1, LINES_IDLE)
        };
        m_seg = S_IDLE;
        m_bit = 4'd0;
        m_ticks = 16'd0;
        m_shift = 8'h00;
        m_attempt = 4'd0;
        m_acked = 1'b1;
        m_rdbyte = 8'h00;
        m_is_read = 1'b0;
        m_reg = 8'h00;
        m_data = 8'h00;
        m_step = 2'd0;
        c_half = i2crm_pkg::HALF_PERIOD_RESET;
        c_retry = i2crm_pkg::RETRY_LIMIT_RESET;
        c_dev = i2crm_pkg::DEVICE_ADDR_RESET;
        gap_pct = 28;
        stall_pct = 86;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_plan[i];
            if (row.is_cfg) begin
                cfg_write(row.reg_idx, row.reg_val);
            end else if (row.reps == 0) begin
                while (m_seg != S_IDLE)
                    send_item(row.kind, row.reg_addr, row.wdata, row.sda, 1'b0, row.want);
            end else begin
                repeat (row.reps)
                    send_item(row.kind, row.reg_addr, row.wdata, row.sda, row.known, row.want);
            end
        end
        dir_items = total_items;

        for (int ph = 0; ph < 3; ph++) begin
            gap_pct = (ph == 0) ? 28 : (ph == 1) ? 86 : 0;
            stall_pct = (ph == 0) ? 86 : (ph == 1) ? 28 : 0;
            if (ph == 1) begin
                // longest segment setting, only idle traffic while it holds
                cfg_write(i2crm_pkg::REG_HALF_PERIOD, 16'hFFFF);
                repeat (12)
                    send_item($urandom_range(0, 1) ? i2crm_pkg::KIND_TICK : KIND_SPARE,
                              8'($urandom), 8'($urandom), 1'($urandom), 1'b0, LINES_IDLE);
            end
            cfg_write(i2crm_pkg::REG_HALF_PERIOD, 16'($urandom_range(0, 2)));
            cfg_write(i2crm_pkg::REG_RETRY_LIMIT, 16'($urandom_range(0, 2)));
            cfg_write(i2crm_pkg::REG_DEVICE_ADDR, 16'($urandom_range(0, 255)));
            goal = work_items + 60;
            run_txn(1'b1);
            while (work_items < goal) run_txn(1'b0);
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d items (%0d from the directed table): %0d writes, %0d reads, %0d %s",
                 total_items, dir_items, n_writes, n_reads, n_rejected,
                 "commands refused while busy.");
        $display("%0d transactions acknowledged, %0d given up after retries, %0d register %s",
                 n_ok, n_gave_up, n_cfg, "writes incl. segment length 0 and 65535.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
